### design/eatrm_pkg.sv
// Package for the Euler angle to rotation matrix pipeline.
// Holds the datapath word type, CORDIC constants and the Q4.30 product.
// No dependencies.
package eatrm_pkg;

    localparam int WORD_BITS    = 34;
    localparam int WBITS        = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int NUM_LANES    = 3;
    localparam int NUM_OUT      = 9;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [WORD_BITS+1:0] wide_t;

    localparam word_t KGAIN = 34'sd652032874;

    localparam word_t ATAN [CORDIC_STEPS] = '{
        34'sh20000000, 34'sh12E4051D, 34'sh09FB385B, 34'sh051111D4, 34'sh028B0D43,
        34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55, 34'sh0028BE53, 34'sh00145F2E,
        34'sh000A2F98, 34'sh000517CC, 34'sh00028BE6, 34'sh000145F3, 34'sh0000A2F9,
        34'sh0000517C, 34'sh000028BE, 34'sh0000145F, 34'sh00000A2F, 34'sh00000517,
        34'sh0000028B, 34'sh00000145, 34'sh000000A2, 34'sh00000051, 34'sh00000028,
        34'sh00000014, 34'sh0000000A, 34'sh00000005, 34'sh00000002, 34'sh00000001
    };

    // Q4.30 product, rounded half up
    function automatic word_t mulq(input word_t a, input word_t b);
        logic signed [2*WORD_BITS-1:0] rnd;
        logic signed [2*WORD_BITS-1:0] p;
        rnd = '0;
        rnd[WBITS-1] = 1'b1;
        p = a * b + rnd;
        return p[WBITS+WORD_BITS-1:WBITS];
    endfunction

endpackage

### design/euler_angles_to_rotation_matrix.sv
// Bunge Euler angles (phi1, Phi, phi2) to the orientation matrix Z(phi2)*X(Phi)*Z(phi1).
// Pipelined CORDIC per angle, two product stages, sum and output rounding.
// Depends on eatrm_pkg.
//
// Usage:
//   s_tdata carries three angles of ANGLE_BITS each, a full turn spanning
//   2^ANGLE_BITS units. m_tdata carries the nine matrix entries m00..m22,
//   each signed fixed point with FRAC_BITS fraction bits, FRAC_BITS+2 wide,
//   saturated to plus or minus one.
//   From an accepted item to its result the pipeline holds one angle
//   reduction stage, 30 CORDIC stages (one micro-rotation each, three
//   lanes side by side), quadrant fix-up, two multiplier stages, one sum
//   stage and the output register. Throughput is one item per cycle unless stalled.
//   When m_tready is low with a result waiting, the whole pipeline holds
//   and s_tready drops; bubbles still move while the output is empty.
//   Reset (aresetn low, synchronous) clears all valid bits; the data
//   registers are not reset.
module euler_angles_to_rotation_matrix #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // angle_first_z, angle_tilt_x, angle_second_z
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0] m_tdata
);

    localparam int STEPS = eatrm_pkg::CORDIC_STEPS;
    localparam int LANES = eatrm_pkg::NUM_LANES;
    localparam int OW    = FRAC_BITS + 2;
    localparam int OUT_W = ((9*OW+7)/8)*8;
    localparam int SH    = eatrm_pkg::WBITS - FRAC_BITS;
    localparam logic signed [37:0] RND = (SH > 0) ? (38'sd1 <<< ((SH > 0) ? SH - 1 : 0)) : 38'sd0;
    localparam logic signed [37:0] LIM = 38'sd1 <<< FRAC_BITS;

    logic en;

    eatrm_pkg::word_t x_reg [STEPS+1][LANES];
    eatrm_pkg::word_t y_reg [STEPS+1][LANES];
    eatrm_pkg::word_t z_reg [STEPS+1][LANES];
    logic [1:0]       q_reg [STEPS+1][LANES];
    logic [STEPS:0]   cv_reg;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // angle reduction to the nearest quarter turn
    for (genvar k = 0; k < LANES; k++) begin : g_prep
        logic [31:0] a32;
        logic [31:0] a_rnd;
        logic [1:0]  q;
        logic [31:0] r;
        assign a32   = {s_tdata[k*ANGLE_BITS +: ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};
        assign a_rnd = a32 + 32'h2000_0000;
        assign q     = a_rnd[31:30];
        assign r     = a32 - {q, 30'b0};
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[0][k] <= eatrm_pkg::KGAIN;
                y_reg[0][k] <= '0;
                z_reg[0][k] <= eatrm_pkg::word_t'($signed(r));
                q_reg[0][k] <= q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg <= '0;
        end else if (en) begin
            cv_reg <= {cv_reg[STEPS-1:0], s_tvalid};
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < STEPS; i++) begin : g_step
        for (genvar k = 0; k < LANES; k++) begin : g_lane
            eatrm_pkg::word_t dx;
            eatrm_pkg::word_t dy;
            assign dx = y_reg[i][k] >>> i;
            assign dy = x_reg[i][k] >>> i;
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (!z_reg[i][k][eatrm_pkg::WORD_BITS-1]) begin
                        x_reg[i+1][k] <= x_reg[i][k] - dx;
                        y_reg[i+1][k] <= y_reg[i][k] + dy;
                        z_reg[i+1][k] <= z_reg[i][k] - eatrm_pkg::ATAN[i];
                    end else begin
                        x_reg[i+1][k] <= x_reg[i][k] + dx;
                        y_reg[i+1][k] <= y_reg[i][k] - dy;
                        z_reg[i+1][k] <= z_reg[i][k] + eatrm_pkg::ATAN[i];
                    end
                    q_reg[i+1][k] <= q_reg[i][k];
                end
            end
        end
    end

    // quadrant fix-up
    eatrm_pkg::word_t cs_reg [LANES];
    eatrm_pkg::word_t sn_reg [LANES];
    logic             tv_reg;

    for (genvar k = 0; k < LANES; k++) begin : g_quad
        eatrm_pkg::word_t cs_next;
        eatrm_pkg::word_t sn_next;
        always_comb begin
            case (q_reg[STEPS][k])
                2'd0: begin
                    cs_next = x_reg[STEPS][k];
                    sn_next = y_reg[STEPS][k];
                end
                2'd1: begin
                    cs_next = -y_reg[STEPS][k];
                    sn_next = x_reg[STEPS][k];
                end
                2'd2: begin
                    cs_next = -x_reg[STEPS][k];
                    sn_next = -y_reg[STEPS][k];
                end
                default: begin
                    cs_next = y_reg[STEPS][k];
                    sn_next = -x_reg[STEPS][k];
                end
            endcase
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                cs_reg[k] <= cs_next;
                sn_reg[k] <= sn_next;
            end
        end
    end

    // first products
    eatrm_pkg::word_t cs1_reg, cc1_reg, c2c1_reg, c2s1_reg, s2c1_reg, s2s1_reg;
    eatrm_pkg::word_t s2s_reg, c2s_reg, ss1_reg, sc1_reg, c2_reg, s2_reg, c_reg;
    logic             pv1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cs1_reg  <= eatrm_pkg::mulq(cs_reg[1], sn_reg[0]);
            cc1_reg  <= eatrm_pkg::mulq(cs_reg[1], cs_reg[0]);
            c2c1_reg <= eatrm_pkg::mulq(cs_reg[2], cs_reg[0]);
            c2s1_reg <= eatrm_pkg::mulq(cs_reg[2], sn_reg[0]);
            s2c1_reg <= eatrm_pkg::mulq(sn_reg[2], cs_reg[0]);
            s2s1_reg <= eatrm_pkg::mulq(sn_reg[2], sn_reg[0]);
            s2s_reg  <= eatrm_pkg::mulq(sn_reg[2], sn_reg[1]);
            c2s_reg  <= eatrm_pkg::mulq(cs_reg[2], sn_reg[1]);
            ss1_reg  <= eatrm_pkg::mulq(sn_reg[1], sn_reg[0]);
            sc1_reg  <= eatrm_pkg::mulq(sn_reg[1], cs_reg[0]);
            c2_reg   <= cs_reg[2];
            s2_reg   <= sn_reg[2];
            c_reg    <= cs_reg[1];
        end
    end

    // second products
    eatrm_pkg::word_t s2cs1_reg, s2cc1_reg, c2cs1_reg, c2cc1_reg;
    eatrm_pkg::word_t b_c2c1_reg, b_c2s1_reg, b_s2c1_reg, b_s2s1_reg;
    eatrm_pkg::word_t b_s2s_reg, b_c2s_reg, b_ss1_reg, b_sc1_reg, b_c_reg;
    logic             pv2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2cs1_reg  <= eatrm_pkg::mulq(s2_reg, cs1_reg);
            s2cc1_reg  <= eatrm_pkg::mulq(s2_reg, cc1_reg);
            c2cs1_reg  <= eatrm_pkg::mulq(c2_reg, cs1_reg);
            c2cc1_reg  <= eatrm_pkg::mulq(c2_reg, cc1_reg);
            b_c2c1_reg <= c2c1_reg;
            b_c2s1_reg <= c2s1_reg;
            b_s2c1_reg <= s2c1_reg;
            b_s2s1_reg <= s2s1_reg;
            b_s2s_reg  <= s2s_reg;
            b_c2s_reg  <= c2s_reg;
            b_ss1_reg  <= ss1_reg;
            b_sc1_reg  <= sc1_reg;
            b_c_reg    <= c_reg;
        end
    end

    // sums
    eatrm_pkg::wide_t m_reg [eatrm_pkg::NUM_OUT];
    logic             sv_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0] <= eatrm_pkg::wide_t'(b_c2c1_reg) - eatrm_pkg::wide_t'(s2cs1_reg);
            m_reg[1] <= eatrm_pkg::wide_t'(b_c2s1_reg) + eatrm_pkg::wide_t'(s2cc1_reg);
            m_reg[2] <= eatrm_pkg::wide_t'(b_s2s_reg);
            m_reg[3] <= -eatrm_pkg::wide_t'(b_s2c1_reg) - eatrm_pkg::wide_t'(c2cs1_reg);
            m_reg[4] <= -eatrm_pkg::wide_t'(b_s2s1_reg) + eatrm_pkg::wide_t'(c2cc1_reg);
            m_reg[5] <= eatrm_pkg::wide_t'(b_c2s_reg);
            m_reg[6] <= eatrm_pkg::wide_t'(b_ss1_reg);
            m_reg[7] <= -eatrm_pkg::wide_t'(b_sc1_reg);
            m_reg[8] <= eatrm_pkg::wide_t'(b_c_reg);
        end
    end

    // round, saturate and pack
    logic [OUT_W-1:0] data_next;
    logic [OUT_W-1:0] data_reg;
    logic             out_v_reg;

    for (genvar k = 0; k < eatrm_pkg::NUM_OUT; k++) begin : g_out
        logic signed [37:0] v;
        logic signed [37:0] sat;
        assign v = (38'(m_reg[k]) + RND) >>> SH;
        always_comb begin
            if (v > LIM) begin
                sat = LIM;
            end else if (v < -LIM) begin
                sat = -LIM;
            end else begin
                sat = v;
            end
        end
        assign data_next[k*OW +: OW] = sat[OW-1:0];
    end
    if (OUT_W > 9*OW) begin : g_pad
        assign data_next[OUT_W-1:9*OW] = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tv_reg    <= 1'b0;
            pv1_reg   <= 1'b0;
            pv2_reg   <= 1'b0;
            sv_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            tv_reg    <= cv_reg[STEPS];
            pv1_reg   <= tv_reg;
            pv2_reg   <= pv1_reg;
            sv_reg    <= pv2_reg;
            out_v_reg <= sv_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = data_reg;

endmodule

### tb/euler_angles_to_rotation_matrix_checker.sv
// Checker for the Euler angle to rotation matrix block: watches both channels,
// predicts each matrix from the accepted angles and compares entry by entry.
// Self-contained; needs no package.
`timescale 1ns / 1ps
module euler_angles_to_rotation_matrix_checker #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  logic s_tready,
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic m_tvalid,
    input  logic m_tready,
    input  logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
    output int   fail_count,
    output int   matrices_pending
);

    localparam int EW = FRAC_BITS + 2;
    typedef logic [9*EW-1:0] matrix_t;

    localparam longint ANG_TAB [30] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
    };

    matrix_t expected_matrices[$];

    function automatic longint q30_product(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    task automatic cos_sin(input logic [ANGLE_BITS-1:0] ang, output longint cs,
                           output longint sn);
        logic [31:0] turn;
        logic [1:0]  quad;
        logic [31:0] resid;
        longint x, y, z, dx, dy;
        turn  = 32'(ang) << (32 - ANGLE_BITS);
        quad  = 2'((turn + 32'h20000000) >> 30);
        resid = turn - (32'(quad) << 30);
        z = longint'($signed(resid));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ANG_TAB[i];
            end else begin
                x += dx; y -= dy; z += ANG_TAB[i];
            end
        end
        case (quad)
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
    endtask

    function automatic logic [EW-1:0] to_entry(longint v);
        longint lim;
        lim = 64'sd1 <<< FRAC_BITS;
        if (FRAC_BITS < 30) v = (v + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return EW'(v);
    endfunction

    task automatic predict_matrix(input logic [3*ANGLE_BITS-1:0] angles,
                                  output matrix_t mat);
        longint c1, s1, c, s, c2, s2, cs1, cc1;
        longint e [9];
        cos_sin(angles[ANGLE_BITS-1:0], c1, s1);
        cos_sin(angles[2*ANGLE_BITS-1:ANGLE_BITS], c, s);
        cos_sin(angles[3*ANGLE_BITS-1:2*ANGLE_BITS], c2, s2);
        cs1 = q30_product(c, s1);
        cc1 = q30_product(c, c1);
        e[0] = q30_product(c2, c1) - q30_product(s2, cs1);
        e[1] = q30_product(c2, s1) + q30_product(s2, cc1);
        e[2] = q30_product(s2, s);
        e[3] = -q30_product(s2, c1) - q30_product(c2, cs1);
        e[4] = -q30_product(s2, s1) + q30_product(c2, cc1);
        e[5] = q30_product(c2, s);
        e[6] = q30_product(s, s1);
        e[7] = -q30_product(s, c1);
        e[8] = c;
        for (int k = 0; k < 9; k++) mat[k*EW +: EW] = to_entry(e[k]);
    endtask

    assign matrices_pending = expected_matrices.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        matrix_t mat;
        matrix_t want;
        if (aresetn && s_tvalid && s_tready) begin
            predict_matrix(s_tdata[3*ANGLE_BITS-1:0], mat);
            expected_matrices = {expected_matrices, mat};
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_matrices.size() == 0) begin
                $display("%0t: unexpected matrix %h", $time, m_tdata);
                fail_count++;
            end else begin
                want = expected_matrices.pop_front();
                for (int k = 0; k < 9; k++)
                    if (m_tdata[k*EW +: EW] !== want[k*EW +: EW]) begin
                        $display("%0t: entry %0d expected %0d actual %0d", $time, k,
                                 $signed(want[k*EW +: EW]), $signed(m_tdata[k*EW +: EW]));
                        fail_count++;
                    end
            end
        end
    end
endmodule

### tb/euler_angles_to_rotation_matrix_tb.sv
// Testbench top for the Euler angle to rotation matrix block: drives angle
// triples with random gaps and stalls and gives the verdict from the checker.
// Depends on the block, eatrm_pkg and euler_angles_to_rotation_matrix_checker.
`timescale 1ns / 1ps
module euler_angles_to_rotation_matrix_tb;
    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int SW = ((3*ANGLE_BITS+7)/8)*8;
    localparam int MW = ((9*(FRAC_BITS+2)+7)/8)*8;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [MW-1:0] m_tdata;
    int fail_count;
    int matrices_pending;
    bit stimulus_done = 0;

    always #4 aclk = ~aclk;

    euler_angles_to_rotation_matrix #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata);

    euler_angles_to_rotation_matrix_checker #(.ANGLE_BITS(ANGLE_BITS),
                                              .FRAC_BITS(FRAC_BITS)) checker_i (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
        .fail_count, .matrices_pending);

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 3) * 16'h4000 + $urandom_range(0, 2) - 1);
            1: return 16'($urandom_range(0, 7) * 16'h2000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_angles(input logic [15:0] a1, input logic [15:0] a2,
                               input logic [15:0] a3, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= SW'({a3, a2, a1});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    logic [15:0] corner [8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
                                16'hC000, 16'h2000, 16'h5555, 16'hAAAA};

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        for (int i = 0; i < 24; i++)
            send_angles(corner[i % 8], corner[(i / 3) % 8], corner[(i * 5 + 1) % 8], 0);
        for (int i = 0; i < 1700; i++)
            send_angles(pick_angle(), pick_angle(), pick_angle(), (i / 150) % 2 == 1);
        s_tvalid <= 0;
        stimulus_done = 1;
    end

    initial begin
        int wait_cycles;
        @(posedge aclk iff aresetn);
        repeat (300) @(posedge aclk);
        m_tready <= 0;
        repeat (200) @(posedge aclk);
        while (!stimulus_done) begin
            wait_cycles = (($urandom_range(0, 3) == 0) || ($time / 8000) % 3 == 0)
                          ? 0 : $urandom_range(0, 5);
            if (wait_cycles > 0) begin
                m_tready <= 0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
        end
        m_tready <= 1;
    end

    initial begin
        @(posedge aclk iff stimulus_done);
        while (matrices_pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule

### sim.f
design/eatrm_pkg.sv
design/euler_angles_to_rotation_matrix.sv
tb/euler_angles_to_rotation_matrix_checker.sv
tb/euler_angles_to_rotation_matrix_tb.sv
